>>> rtl/core/nrp_pkg.sv
// Shared constants, types and helpers for the NMEA RMC position parser.
`timescale 1ns / 1ps

package nrp_pkg;

  // ASCII codes seen in the sentence stream
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_FIX_OK = 8'h41;  // 'A'
  localparam logic [7:0] TAG_RESET = 8'h43;  // 'C'

  localparam int POS_W = 27;

  // saturation limit for the 3-bit counters, tag offset, field numbers
  localparam logic [2:0] CNT_SAT    = 3'd7;
  localparam logic [2:0] TAG_POS    = 3'd5;
  localparam logic [2:0] FLD_STATUS = 3'd2;
  localparam logic [2:0] FLD_LAT    = 3'd3;
  localparam logic [2:0] FLD_LON    = 3'd5;

  localparam longint unsigned DEG_SCALE   = 100000;
  localparam longint unsigned MIN_PER_DEG = 60;
  localparam longint unsigned DEG_DIV     = 100;  // ddmm -> dd, mm

  // one conversion job travelling down the scaling pipe
  typedef struct packed {
    logic vld;
    logic is_lon;
    logic fix;
  } job_ctl_t;

  function automatic longint unsigned pow10(input int n);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < n && i < 18; i++) p = p * 10;
    return p;
  endfunction

endpackage

>>> rtl/core/nrp_rx_if.sv
// Byte input channel of the NMEA RMC position parser.
`timescale 1ns / 1ps

interface nrp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/nrp_pos_if.sv
// Position result channel of the NMEA RMC position parser.
`timescale 1ns / 1ps

interface nrp_pos_if import nrp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             fix_valid;
  logic [POS_W-1:0] latitude_scaled;
  logic [POS_W-1:0] longitude_scaled;

  modport source (output valid, output fix_valid, output latitude_scaled,
                  output longitude_scaled, input ready);
  modport sink   (input valid, input fix_valid, input latitude_scaled,
                  input longitude_scaled, output ready);
endinterface

>>> rtl/core/nrp_parser.sv
// Byte-level sentence tracker: tag check, field count and digit accumulation.
`timescale 1ns / 1ps

module nrp_parser import nrp_pkg::*; #(
  parameter int FRACTION_DIGITS = 5,
  parameter int INTEGER_DIGITS  = 5,
  localparam int IAW = $clog2(pow10(INTEGER_DIGITS)),
  localparam int FAW = $clog2(pow10(FRACTION_DIGITS)),
  localparam int FCW = $clog2(FRACTION_DIGITS + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           acc,
  input  logic [7:0]     rx_byte,
  input  logic [7:0]     sentence_tag,
  output job_ctl_t       job,
  output logic [IAW-1:0] ia,
  output logic [FAW-1:0] fa,
  output logic [FCW-1:0] fdc
);

  logic           in_sent_r, in_sent_nxt;
  logic [2:0]     cp_r, cp_nxt;
  logic [2:0]     fi_r, fi_nxt;
  logic           tag_r, tag_nxt;
  logic           malf_r, malf_nxt;
  logic           stat_r, stat_nxt;
  logic [IAW-1:0] ia_r, ia_nxt;
  logic [2:0]     idc_r, idc_nxt;
  logic [FAW-1:0] fa_r, fa_nxt;
  logic [FCW-1:0] fdc_r, fdc_nxt;
  logic           infr_r, infr_nxt;
  logic [3:0]     digit;
  logic           is_digit;

  assign digit    = 4'(rx_byte - CH_ZERO);
  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

  always_comb begin
    in_sent_nxt = in_sent_r;
    cp_nxt      = cp_r;
    fi_nxt      = fi_r;
    tag_nxt     = tag_r;
    malf_nxt    = malf_r;
    stat_nxt    = stat_r;
    ia_nxt      = ia_r;
    idc_nxt     = idc_r;
    fa_nxt      = fa_r;
    fdc_nxt     = fdc_r;
    infr_nxt    = infr_r;
    job         = '0;
    if (acc) begin
      if (rx_byte == CH_DOLLAR) begin
        in_sent_nxt = 1'b1;
        cp_nxt      = '0;
        fi_nxt      = '0;
        tag_nxt     = 1'b0;
        malf_nxt    = 1'b0;
        stat_nxt    = 1'b0;
        ia_nxt      = '0;
        idc_nxt     = '0;
        fa_nxt      = '0;
        fdc_nxt     = '0;
        infr_nxt    = 1'b0;
      end else if (in_sent_r) begin
        if (cp_r != CNT_SAT) begin
          cp_nxt = cp_r + 3'd1;
          if (cp_nxt == TAG_POS) begin
            tag_nxt = (rx_byte == sentence_tag);
          end
        end
        if (rx_byte == CH_COMMA) begin
          // field end: latitude always converted, longitude only if sentence good
          job.is_lon = (fi_r == FLD_LON);
          job.fix    = stat_r;
          job.vld    = (fi_r == FLD_LAT) || ((fi_r == FLD_LON) && tag_nxt && !malf_r);
          if (fi_r != CNT_SAT) begin
            fi_nxt = fi_r + 3'd1;
          end
          ia_nxt   = '0;
          idc_nxt  = '0;
          fa_nxt   = '0;
          fdc_nxt  = '0;
          infr_nxt = 1'b0;
        end else if (fi_r == FLD_STATUS) begin
          // idc doubles as byte count of the status field
          stat_nxt = (idc_r == 3'd0) && (rx_byte == CH_FIX_OK);
          if (idc_r != CNT_SAT) begin
            idc_nxt = idc_r + 3'd1;
          end
        end else if ((fi_r == FLD_LAT) || (fi_r == FLD_LON)) begin
          if (is_digit) begin
            if (!infr_r) begin
              if (idc_r < 3'(INTEGER_DIGITS)) begin
                ia_nxt  = IAW'(ia_r * 4'd10 + IAW'(digit));
                idc_nxt = idc_r + 3'd1;
              end else begin
                malf_nxt = 1'b1;
              end
            end else if (fdc_r < FCW'(FRACTION_DIGITS)) begin
              fa_nxt  = FAW'(fa_r * 4'd10 + FAW'(digit));
              fdc_nxt = fdc_r + FCW'(1);
            end
          end else if ((rx_byte == CH_DOT) && !infr_r) begin
            infr_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sent_r <= 1'b0;
      cp_r      <= '0;
      fi_r      <= '0;
      tag_r     <= 1'b0;
      malf_r    <= 1'b0;
      stat_r    <= 1'b0;
      ia_r      <= '0;
      idc_r     <= '0;
      fa_r      <= '0;
      fdc_r     <= '0;
      infr_r    <= 1'b0;
    end else begin
      in_sent_r <= in_sent_nxt;
      cp_r      <= cp_nxt;
      fi_r      <= fi_nxt;
      tag_r     <= tag_nxt;
      malf_r    <= malf_nxt;
      stat_r    <= stat_nxt;
      ia_r      <= ia_nxt;
      idc_r     <= idc_nxt;
      fa_r      <= fa_nxt;
      fdc_r     <= fdc_nxt;
      infr_r    <= infr_nxt;
    end
  end

  assign ia  = ia_r;
  assign fa  = fa_r;
  assign fdc = fdc_r;

endmodule

>>> rtl/core/nrp_scale.sv
// Six-stage pipe turning ddmm.mmmm digits into degrees times 100000.
`timescale 1ns / 1ps

module nrp_scale import nrp_pkg::*; #(
  parameter int FRACTION_DIGITS = 5,
  parameter int INTEGER_DIGITS  = 5,
  localparam int IAW = $clog2(pow10(INTEGER_DIGITS)),
  localparam int FAW = $clog2(pow10(FRACTION_DIGITS)),
  localparam int FCW = $clog2(FRACTION_DIGITS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  job_ctl_t         job_in,
  input  logic [IAW-1:0]   ia_in,
  input  logic [FAW-1:0]   fa_in,
  input  logic [FCW-1:0]   fdc_in,
  output logic             busy,
  output job_ctl_t         res_ctl,
  output logic [POS_W-1:0] res_pos
);

  // q = floor(m * 100000 / (60 * 10^F)) rewritten as floor(x / DIV), x = m * MUL
  localparam longint unsigned DEN    = MIN_PER_DEG * pow10(FRACTION_DIGITS);
  localparam longint unsigned MUL    = (DEN > DEG_SCALE) ? 1 : (DEG_SCALE * 6) / DEN;
  localparam longint unsigned DIV    = (DEN * MUL) / DEG_SCALE;
  localparam longint unsigned MINMUL = pow10(FRACTION_DIGITS) * MUL;
  localparam longint unsigned XMAX   = pow10(FRACTION_DIGITS + 2) * MUL;
  localparam int XW   = $clog2(XMAX);
  localparam int QW   = $clog2(XMAX / DIV + 1);
  localparam int DEGW = $clog2(pow10(INTEGER_DIGITS - 2));
  localparam int DSW  = $clog2(pow10(INTEGER_DIGITS - 2) * DEG_SCALE);
  localparam int FMW  = FAW + 1;
  localparam int MINW = 7;
  // reciprocals; estimate is low by at most one
  localparam logic [IAW-1:0] R100 = IAW'((longint'(1) << IAW) / DEG_DIV);
  localparam logic [XW-1:0]  RDIV = XW'((longint'(1) << XW) / DIV);

  job_ctl_t          p1_ctl, p2_ctl, p3_ctl, p4_ctl, p5_ctl, p6_ctl;
  logic [IAW-1:0]    p1_ia;
  logic [DEGW-1:0]   p1_deg0, p2_deg;
  logic [FAW-1:0]    p1_fsc, p2_fsc;
  logic [MINW-1:0]   p2_min;
  logic [XW-1:0]     p3_x, p4_x;
  logic [DSW-1:0]    p3_degs, p4_degs, p5_degs;
  logic [QW-1:0]     p4_q0, p5_q;
  logic [POS_W-1:0]  p6_pos;

  logic [FMW-1:0]    fmul;
  logic [2*IAW-1:0]  prod1;
  logic [IAW-1:0]    rem1;
  logic              ge1;
  logic [2*XW-1:0]   prod4;
  logic [XW-1:0]     rem5;

  always_comb begin
    fmul = '0;
    for (int k = 0; k <= FRACTION_DIGITS; k++) begin
      if (fdc_in == FCW'(k)) fmul = FMW'(pow10(FRACTION_DIGITS - k));
    end
  end

  assign prod1 = ia_in * R100;
  assign rem1  = p1_ia - IAW'(p1_deg0 * DEG_DIV);
  assign ge1   = (rem1 >= IAW'(DEG_DIV));
  assign prod4 = p3_x * RDIV;
  assign rem5  = p4_x - XW'(p4_q0 * DIV);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_ctl <= '0;
      p2_ctl <= '0;
      p3_ctl <= '0;
      p4_ctl <= '0;
      p5_ctl <= '0;
      p6_ctl <= '0;
    end else if (adv) begin
      p1_ctl <= job_in;
      p2_ctl <= p1_ctl;
      p3_ctl <= p2_ctl;
      p4_ctl <= p3_ctl;
      p5_ctl <= p4_ctl;
      p6_ctl <= p5_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // degree estimate, fraction aligned to F digits
      p1_ia   <= ia_in;
      p1_deg0 <= prod1[IAW +: DEGW];
      p1_fsc  <= FAW'(fa_in * fmul);
      // fix degree estimate, split off minutes
      p2_deg  <= p1_deg0 + DEGW'(ge1);
      p2_min  <= MINW'(ge1 ? rem1 - IAW'(DEG_DIV) : rem1);
      p2_fsc  <= p1_fsc;
      // scaled minutes numerator, degree part
      p3_x    <= XW'(p2_min * MINMUL + p2_fsc * MUL);
      p3_degs <= DSW'(p2_deg * DEG_SCALE);
      // quotient estimate
      p4_x    <= p3_x;
      p4_q0   <= prod4[XW +: QW];
      p4_degs <= p3_degs;
      // one-step correction
      p5_q    <= p4_q0 + QW'(rem5 >= XW'(DIV));
      p5_degs <= p4_degs;
      p6_pos  <= POS_W'(32'(p5_degs) + 32'(p5_q));
    end
  end

  assign busy    = p1_ctl.vld | p2_ctl.vld | p3_ctl.vld | p4_ctl.vld | p5_ctl.vld | p6_ctl.vld;
  assign res_ctl = p6_ctl;
  assign res_pos = p6_pos;

endmodule

>>> rtl/core/nmea_rmc_position_parser.sv
// Top level of the NMEA RMC position parser: config register, pipe, result register.
`timescale 1ns / 1ps

// Usage
//   in_rx   : NMEA text, one byte per beat (valid/ready).
//   out_pos : one beat per good sentence - fix flag, latitude and longitude in
//             degrees x 100000 - issued once the field 5 conversion completes.
//   cfg_we / cfg_wdata : sentence tag byte checked at offset five ('C' at reset).
// Throughput: one byte per cycle while in_rx ready is high. Parsing is a
//   per-byte register update; field conversion runs in a six-stage pipe
//   (reciprocal multiplies for /100 and /60), then the result register.
// Reset (rst_n low, synchronous): sentence tracking idles until the next '$',
//   the pipe and the result register empty, the tag returns to 'C'.
// Stall: the result register holds its beat while out_pos.ready is low. Bytes
//   keep flowing unless a conversion is in flight while a beat is held; then in_rx
//   ready stays low until the held beat clears or the pipe empties.
// Latitude from field 3 is kept until field 5 of the same sentence completes.

module nmea_rmc_position_parser import nrp_pkg::*; #(
  parameter int FRACTION_DIGITS = 5,
  parameter int INTEGER_DIGITS  = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  nrp_rx_if.sink     in_rx,
  nrp_pos_if.source  out_pos
);

  localparam int IAW = $clog2(pow10(INTEGER_DIGITS));
  localparam int FAW = $clog2(pow10(FRACTION_DIGITS));
  localparam int FCW = $clog2(FRACTION_DIGITS + 1);

  logic [7:0]       sentence_tag_r;
  logic             acc;
  job_ctl_t         job;
  logic [IAW-1:0]   ia;
  logic [FAW-1:0]   fa;
  logic [FCW-1:0]   fdc;
  logic             busy;
  logic             adv;
  job_ctl_t         res_ctl;
  logic [POS_W-1:0] res_pos;
  logic             lon_load;
  logic [POS_W-1:0] lat_held_r;
  logic             out_valid_r, out_valid_nxt;
  logic             out_fix_r;
  logic [POS_W-1:0] out_lat_r;
  logic [POS_W-1:0] out_lon_r;

  // tag register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sentence_tag_r <= TAG_RESET;
    end else if (cfg_we) begin
      sentence_tag_r <= cfg_wdata;
    end
  end

  // pipe stalls only with a longitude result blocked at the output register
  assign adv         = !(res_ctl.vld && res_ctl.is_lon && out_valid_r && !out_pos.ready);
  assign in_rx.ready = !(out_valid_r && busy);
  assign acc         = in_rx.valid && in_rx.ready;
  assign lon_load    = res_ctl.vld && res_ctl.is_lon && adv;

  nrp_parser #(
    .FRACTION_DIGITS (FRACTION_DIGITS),
    .INTEGER_DIGITS  (INTEGER_DIGITS)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .rx_byte      (in_rx.rx_byte),
    .sentence_tag (sentence_tag_r),
    .job          (job),
    .ia           (ia),
    .fa           (fa),
    .fdc          (fdc)
  );

  nrp_scale #(
    .FRACTION_DIGITS (FRACTION_DIGITS),
    .INTEGER_DIGITS  (INTEGER_DIGITS)
  ) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .job_in  (job),
    .ia_in   (ia),
    .fa_in   (fa),
    .fdc_in  (fdc),
    .busy    (busy),
    .res_ctl (res_ctl),
    .res_pos (res_pos)
  );

  // latitude kept for the longitude of the same sentence (jobs stay in order)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_held_r <= '0;
    end else if (res_ctl.vld && !res_ctl.is_lon) begin
      lat_held_r <= res_pos;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_pos.ready) out_valid_nxt = 1'b0;
    if (lon_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (lon_load) begin
      out_fix_r <= res_ctl.fix;
      out_lat_r <= lat_held_r;
      out_lon_r <= res_pos;
    end
  end

  assign out_pos.valid            = out_valid_r;
  assign out_pos.fix_valid        = out_fix_r;
  assign out_pos.latitude_scaled  = out_lat_r;
  assign out_pos.longitude_scaled = out_lon_r;

`ifndef ASSERT_OFF
  // a new conversion never enters a stalled pipe
  a_no_inject_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    job.vld |-> adv)
    else $error("conversion job injected while pipe stalled");

  // a held result beat is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pos.ready) |-> !lon_load)
    else $error("result register overwritten while stalled");

  // a longitude leaving the pipe shows up as a result beat
  a_lon_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    lon_load |=> out_valid_r)
    else $error("longitude result lost");

  // held latitude only changes when a latitude conversion completes
  a_lat_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!$stable(lat_held_r) && $past(rst_n)) |-> $past(res_ctl.vld && !res_ctl.is_lon))
    else $error("held latitude changed without a latitude result");
`endif

endmodule
